@@ rtl/core/lbm_pkg.sv @@
// Shared types, codes and constants for the latched pattern-bank mapper.
// No dependencies; every other file of the block refers to it by scoped names.
package lbm_pkg;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int REGION_W   = 4;
  localparam int MADDR_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PRG_BANK_W = 4;
  localparam int CHR_BANK_W = 5;
  localparam int CHR_BANKS  = 4;

  // Default address widths of the ROMs
  localparam int PRG_ADDR_BITS_DEF = 17;
  localparam int CHR_ADDR_BITS_DEF = 17;

  // Size limits
  localparam logic [4:0] PRG_LOG2_MIN = 5'd15;
  localparam logic [4:0] CHR_LOG2_MIN = 5'd12;

  // Bus commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_READ  = 3'd0,
    CMD_CPU_WRITE = 3'd1,
    CMD_PPU_LATCH = 3'd2,
    CMD_PPU_READ  = 3'd3,
    CMD_PPU_WRITE = 3'd4
  } cmd_t;

  // Target regions
  localparam logic [REGION_W-1:0] RGN_NONE      = 4'd0;
  localparam logic [REGION_W-1:0] RGN_SYSRAM    = 4'd1;
  localparam logic [REGION_W-1:0] RGN_PPU_REGS  = 4'd2;
  localparam logic [REGION_W-1:0] RGN_APU_REGS  = 4'd3;
  localparam logic [REGION_W-1:0] RGN_BACKUP    = 4'd4;
  localparam logic [REGION_W-1:0] RGN_PRG_ROM   = 4'd5;
  localparam logic [REGION_W-1:0] RGN_CHR_ROM   = 4'd6;
  localparam logic [REGION_W-1:0] RGN_CHR_RAM   = 4'd7;
  localparam logic [REGION_W-1:0] RGN_NAMETABLE = 4'd8;
  localparam logic [REGION_W-1:0] RGN_MAPPER    = 4'd9;

  // CPU address windows, address[15:13]
  localparam logic [2:0] CPU_WIN_SYSRAM = 3'd0;
  localparam logic [2:0] CPU_WIN_PPU    = 3'd1;
  localparam logic [2:0] CPU_WIN_APU    = 3'd2;
  localparam logic [2:0] CPU_WIN_BACKUP = 3'd3;
  localparam logic [2:0] CPU_WIN_PRG_SW = 3'd4;

  // Mapper register select, address[15:12]
  localparam logic [3:0] MREG_PRG  = 4'hA;
  localparam logic [3:0] MREG_CHR0 = 4'hB;
  localparam logic [3:0] MREG_CHR1 = 4'hC;
  localparam logic [3:0] MREG_CHR2 = 4'hD;
  localparam logic [3:0] MREG_CHR3 = 4'hE;

  // Magic tile rows, PPU address[12:4]
  localparam logic [8:0] TILE_LOW_FD  = 9'h0FD;
  localparam logic [8:0] TILE_LOW_FE  = 9'h0FE;
  localparam logic [8:0] TILE_HIGH_FD = 9'h1FD;
  localparam logic [8:0] TILE_HIGH_FE = 9'h1FE;

  // Pattern window, PPU address[13:12]
  localparam logic [1:0] VWIN_LOW  = 2'd0;
  localparam logic [1:0] VWIN_HIGH = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_PRES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_MASK = 3'd3;

  // One input word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } item_t;

  // Derived configuration seen by the decoder
  typedef struct packed {
    logic [PRG_BANK_W-1:0] prg_mask;
    logic [CHR_BANK_W-1:0] chr_mask;
    logic [MADDR_W-1:0]    prg_top;
    logic                  backup_present;
    logic [12:0]           backup_mask;
  } cfg_t;

  // Current mapper state
  typedef struct packed {
    logic [PRG_BANK_W-1:0]                 prg_bank;
    logic [CHR_BANKS-1:0][CHR_BANK_W-1:0]  chr_bank;
    logic                                  low_latch;
    logic                                  high_latch;
    logic                                  mirror;
    logic [ADDR_W-1:0]                     video_addr;
  } bank_state_t;

  // State updates caused by one word
  typedef struct packed {
    logic                  prg_we;
    logic [CHR_BANKS-1:0]  chr_we;
    logic                  mirror_we;
    logic                  va_we;
    logic                  low_we;
    logic                  low_val;
    logic                  high_we;
    logic                  high_val;
    logic [PRG_BANK_W-1:0] prg_val;
    logic [CHR_BANK_W-1:0] chr_val;
    logic                  mirror_val;
    logic [ADDR_W-1:0]     va_val;
  } bank_upd_t;

  // One result word
  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [MADDR_W-1:0]  mem_addr;
    logic                is_write;
    logic [DATA_W-1:0]   write_data;
    logic                mirror_horizontal;
  } result_t;

endpackage

@@ rtl/core/latched_chr_bank_mapper.sv @@
// Latched pattern-bank cartridge mapper, top level.
// Throughput: one word per cycle unless out_stall holds a valid result; an input register
// and a result register frame the decode, and the result register drives out_*.
// Reset (rst_n low, synchronous): pipeline empties, banks and mirroring clear, both tile
// latches set, video address clears, configuration returns to its reset values.
// Depends on lbm_pkg, lbm_cfg_regs, lbm_bank_regs, lbm_decode.
module latched_chr_bank_mapper #(
  parameter int PRG_ADDR_BITS = lbm_pkg::PRG_ADDR_BITS_DEF,
  parameter int CHR_ADDR_BITS = lbm_pkg::CHR_ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lbm_pkg::CMD_W-1:0]        in_command,
  input  logic [lbm_pkg::ADDR_W-1:0]       in_address,
  input  logic [lbm_pkg::DATA_W-1:0]       in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lbm_pkg::REGION_W-1:0]     out_region,
  output logic [lbm_pkg::MADDR_W-1:0]      out_mem_addr,
  output logic                             out_is_write,
  output logic [lbm_pkg::DATA_W-1:0]       out_write_data,
  output logic                             out_mirror_horizontal,
  // configuration port
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                  s1_valid_r;
  lbm_pkg::item_t        s1_item_r;
  logic                  out_valid_r;
  lbm_pkg::result_t      out_res_r;
  logic                  adv;
  logic                  in_ready;
  logic                  fire;
  lbm_pkg::cfg_t         cfg;
  lbm_pkg::bank_state_t  state;
  lbm_pkg::result_t      res;
  lbm_pkg::bank_upd_t    upd;

  // Pipeline handshake
  assign adv      = !out_valid_r || !out_stall;
  assign in_ready = !s1_valid_r || adv;
  assign in_stall = !in_ready;
  assign fire     = s1_valid_r && adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.command <= in_command;
      s1_item_r.address <= in_address;
      s1_item_r.data    <= in_data;
    end
  end

  lbm_cfg_regs #(
    .PRG_ADDR_BITS (PRG_ADDR_BITS),
    .CHR_ADDR_BITS (CHR_ADDR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbm_bank_regs u_banks (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .upd   (upd),
    .state (state)
  );

  lbm_decode u_decode (
    .item  (s1_item_r),
    .cfg   (cfg),
    .state (state),
    .res   (res),
    .upd   (upd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_region            = out_res_r.region;
  assign out_mem_addr          = out_res_r.mem_addr;
  assign out_is_write          = out_res_r.is_write;
  assign out_write_data        = out_res_r.write_data;
  assign out_mirror_horizontal = out_res_r.mirror_horizontal;

endmodule

@@ rtl/core/lbm_cfg_regs.sv @@
// Configuration registers and the bank masks and fixed-window base derived from them.
// Depends on lbm_pkg.
module lbm_cfg_regs #(
  parameter int PRG_ADDR_BITS = lbm_pkg::PRG_ADDR_BITS_DEF,
  parameter int CHR_ADDR_BITS = lbm_pkg::CHR_ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lbm_pkg::cfg_t                    cfg
);

  localparam logic [4:0] PRG_LOG2_MAX = 5'(PRG_ADDR_BITS);
  localparam logic [4:0] CHR_LOG2_MAX = 5'(CHR_ADDR_BITS);

  logic [4:0]  prg_size_r;
  logic [4:0]  chr_size_r;
  logic        backup_pres_r;
  logic [12:0] backup_mask_r;
  logic [4:0]  prg_l;
  logic [4:0]  chr_l;

  // Always ready; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  // Capture register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_r    <= 5'd17;
      chr_size_r    <= 5'd17;
      backup_pres_r <= 1'b0;
      backup_mask_r <= 13'h1FFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbm_pkg::CFG_PRG_SIZE:    prg_size_r    <= cfg_data[4:0];
        lbm_pkg::CFG_CHR_SIZE:    chr_size_r    <= cfg_data[4:0];
        lbm_pkg::CFG_BACKUP_PRES: backup_pres_r <= cfg_data[0];
        lbm_pkg::CFG_BACKUP_MASK: backup_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the supported range
  always_comb begin
    if (prg_size_r < lbm_pkg::PRG_LOG2_MIN)  prg_l = lbm_pkg::PRG_LOG2_MIN;
    else if (prg_size_r > PRG_LOG2_MAX)      prg_l = PRG_LOG2_MAX;
    else                                     prg_l = prg_size_r;
    if (chr_size_r < lbm_pkg::CHR_LOG2_MIN)  chr_l = lbm_pkg::CHR_LOG2_MIN;
    else if (chr_size_r > CHR_LOG2_MAX)      chr_l = CHR_LOG2_MAX;
    else                                     chr_l = chr_size_r;
  end

  // Build masks and the base of the fixed top 32K window
  always_comb begin
    for (int i = 0; i < lbm_pkg::PRG_BANK_W; i++) begin
      cfg.prg_mask[i] = (5'(i + 13) < prg_l);
    end
    for (int i = 0; i < lbm_pkg::CHR_BANK_W; i++) begin
      cfg.chr_mask[i] = (5'(i + 12) < chr_l);
    end
    for (int i = 0; i < lbm_pkg::MADDR_W; i++) begin
      cfg.prg_top[i] = (i >= 15) && (5'(i) < prg_l);
    end
    cfg.backup_present = backup_pres_r;
    cfg.backup_mask    = backup_mask_r;
  end

endmodule

@@ rtl/core/lbm_bank_regs.sv @@
// Mapper state: program bank, pattern banks, tile latches, mirroring, video address.
// Depends on lbm_pkg.
module lbm_bank_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  lbm_pkg::bank_upd_t    upd,
  output lbm_pkg::bank_state_t  state
);

  lbm_pkg::bank_state_t state_r;

  assign state = state_r;

  // Apply the updates of the word leaving decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prg_bank   <= '0;
      state_r.chr_bank   <= '0;
      state_r.low_latch  <= 1'b1;
      state_r.high_latch <= 1'b1;
      state_r.mirror     <= 1'b0;
      state_r.video_addr <= '0;
    end else if (fire) begin
      if (upd.prg_we) state_r.prg_bank <= upd.prg_val;
      for (int i = 0; i < lbm_pkg::CHR_BANKS; i++) begin
        if (upd.chr_we[i]) state_r.chr_bank[i] <= upd.chr_val;
      end
      if (upd.mirror_we) state_r.mirror     <= upd.mirror_val;
      if (upd.va_we)     state_r.video_addr <= upd.va_val;
      if (upd.low_we)    state_r.low_latch  <= upd.low_val;
      if (upd.high_we)   state_r.high_latch <= upd.high_val;
    end
  end

endmodule

@@ rtl/core/lbm_decode.sv @@
// Combinational access decode: region, translated address and state updates.
// Depends on lbm_pkg.
module lbm_decode (
  input  lbm_pkg::item_t        item,
  input  lbm_pkg::cfg_t         cfg,
  input  lbm_pkg::bank_state_t  state,
  output lbm_pkg::result_t      res,
  output lbm_pkg::bank_upd_t    upd
);

  logic [2:0]                       cpu_win;
  logic [1:0]                       vwin;
  logic [lbm_pkg::CHR_BANK_W-1:0]   chr_sel;
  logic                             wr;

  assign cpu_win = item.address[15:13];
  assign vwin    = state.video_addr[13:12];

  always_comb begin
    res.region   = lbm_pkg::RGN_NONE;
    res.mem_addr = '0;
    wr           = 1'b0;
    chr_sel      = '0;
    upd          = '0;
    upd.prg_val    = item.data[3:0] & cfg.prg_mask;
    upd.chr_val    = item.data[4:0] & cfg.chr_mask;
    upd.mirror_val = item.data[0];
    upd.va_val     = item.address;

    case (lbm_pkg::cmd_t'(item.command))
      lbm_pkg::CMD_CPU_READ, lbm_pkg::CMD_CPU_WRITE: begin
        // CPU side: decode by 8K window
        case (cpu_win)
          lbm_pkg::CPU_WIN_SYSRAM: begin
            res.region   = lbm_pkg::RGN_SYSRAM;
            res.mem_addr = {6'd0, item.address[10:0]};
            wr           = item.command[0];
          end
          lbm_pkg::CPU_WIN_PPU: begin
            res.region   = lbm_pkg::RGN_PPU_REGS;
            res.mem_addr = {1'b0, item.address};
            wr           = item.command[0];
          end
          lbm_pkg::CPU_WIN_APU: begin
            res.region   = lbm_pkg::RGN_APU_REGS;
            res.mem_addr = {1'b0, item.address};
            wr           = item.command[0];
          end
          lbm_pkg::CPU_WIN_BACKUP: begin
            if (cfg.backup_present) begin
              res.region   = lbm_pkg::RGN_BACKUP;
              res.mem_addr = {4'd0, item.address[12:0] & cfg.backup_mask};
              wr           = item.command[0];
            end
          end
          default: begin
            if (!item.command[0]) begin
              // Program ROM: switchable 8K at 0x8000, fixed top above
              res.region = lbm_pkg::RGN_PRG_ROM;
              if (cpu_win == lbm_pkg::CPU_WIN_PRG_SW) begin
                res.mem_addr = {state.prg_bank, item.address[12:0]};
              end else begin
                res.mem_addr = cfg.prg_top | {2'b00, item.address[14:0]};
              end
            end else if (cpu_win != lbm_pkg::CPU_WIN_PRG_SW) begin
              // Mapper register write
              res.region   = lbm_pkg::RGN_MAPPER;
              res.mem_addr = {1'b0, item.address};
              wr           = 1'b1;
              case (item.address[15:12])
                lbm_pkg::MREG_PRG:  upd.prg_we    = 1'b1;
                lbm_pkg::MREG_CHR0: upd.chr_we[0] = 1'b1;
                lbm_pkg::MREG_CHR1: upd.chr_we[1] = 1'b1;
                lbm_pkg::MREG_CHR2: upd.chr_we[2] = 1'b1;
                lbm_pkg::MREG_CHR3: upd.chr_we[3] = 1'b1;
                default:            upd.mirror_we = 1'b1;
              endcase
            end
          end
        endcase
      end
      lbm_pkg::CMD_PPU_LATCH: begin
        // Latch the video address and watch for the magic tile rows
        upd.va_we = 1'b1;
        case (item.address[12:4])
          lbm_pkg::TILE_LOW_FD: begin
            upd.low_we  = 1'b1;
            upd.low_val = 1'b0;
          end
          lbm_pkg::TILE_LOW_FE: begin
            upd.low_we  = 1'b1;
            upd.low_val = 1'b1;
          end
          lbm_pkg::TILE_HIGH_FD: begin
            upd.high_we  = 1'b1;
            upd.high_val = 1'b0;
          end
          lbm_pkg::TILE_HIGH_FE: begin
            upd.high_we  = 1'b1;
            upd.high_val = 1'b1;
          end
          default: ;
        endcase
      end
      lbm_pkg::CMD_PPU_READ: begin
        // Pattern halves pick their bank by latch; the rest is nametable
        case (vwin)
          lbm_pkg::VWIN_LOW: begin
            chr_sel      = state.low_latch ? state.chr_bank[1] : state.chr_bank[0];
            res.region   = lbm_pkg::RGN_CHR_ROM;
            res.mem_addr = {chr_sel, state.video_addr[11:0]};
          end
          lbm_pkg::VWIN_HIGH: begin
            chr_sel      = state.high_latch ? state.chr_bank[3] : state.chr_bank[2];
            res.region   = lbm_pkg::RGN_CHR_ROM;
            res.mem_addr = {chr_sel, state.video_addr[11:0]};
          end
          default: begin
            res.region   = lbm_pkg::RGN_NAMETABLE;
            res.mem_addr = {5'd0, state.video_addr[11:0]};
          end
        endcase
      end
      lbm_pkg::CMD_PPU_WRITE: begin
        wr = 1'b1;
        if (!state.video_addr[13]) begin
          res.region   = lbm_pkg::RGN_CHR_RAM;
          res.mem_addr = {4'd0, state.video_addr[12:0]};
        end else begin
          res.region   = lbm_pkg::RGN_NAMETABLE;
          res.mem_addr = {5'd0, state.video_addr[11:0]};
        end
      end
      default: ;
    endcase

    res.is_write          = wr;
    res.write_data        = wr ? item.data : '0;
    res.mirror_horizontal = upd.mirror_we ? upd.mirror_val : state.mirror;
  end

endmodule

@@ rtl/core/lbm_checker.sv @@
// Port-level checks for the latched pattern-bank mapper, bound to the top level.
// Depends on lbm_pkg and latched_chr_bank_mapper.
module lbm_port_checks (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [lbm_pkg::REGION_W-1:0]     out_region,
  input logic [lbm_pkg::MADDR_W-1:0]      out_mem_addr,
  input logic                             out_is_write,
  input logic [lbm_pkg::DATA_W-1:0]       out_write_data
);

  // Drop results out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mem_addr) && $stable(out_region))
    else $error("stalled result changed");

  // No region means no address and no write
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == lbm_pkg::RGN_NONE |-> out_mem_addr == '0 && !out_is_write)
    else $error("empty region carries address or write");

  // Write data only rides with a write
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_write |-> out_write_data == '0)
    else $error("write data without write");

  // ROM regions are never written
  a_rom_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_region == lbm_pkg::RGN_PRG_ROM || out_region == lbm_pkg::RGN_CHR_ROM)
      |-> !out_is_write)
    else $error("write to ROM region");

endmodule

bind latched_chr_bank_mapper lbm_port_checks u_lbm_port_checks (.*);
